// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, sizes and the character font for the scrolling display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  localparam int unsigned BUFFER_DEPTH = 64;
  localparam int unsigned DIGIT_COUNT  = 4;

  localparam int unsigned ADDR_W  = $clog2(BUFFER_DEPTH);
  localparam int unsigned LEN_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned OFF_W   = ADDR_W;
  localparam int unsigned DIGIT_W = 2;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OP_W    = 2;

  localparam logic [LEN_W-1:0]   DEPTH_L     = LEN_W'(BUFFER_DEPTH);
  localparam logic [LEN_W-1:0]   DIGITS_L    = LEN_W'(DIGIT_COUNT);
  localparam logic [DIGIT_W-1:0] LAST_DIGIT  = DIGIT_W'(DIGIT_COUNT - 1);
  localparam logic [SEG_W-1:0]   DP_ONLY     = 8'h80;
  localparam logic [SEG_W-1:0]   SEG_BLANK   = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_END    = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_MUX   = 2'd1,
    OP_SHIFT = 2'd2
  } opcode_t;

  // Multiplex request handed from the control stage to the output stage.
  typedef struct packed {
    logic               vld;
    logic [DIGIT_W-1:0] digit;
    logic               blank;
  } mux_req_t;

  // A..G in bits 0..6, DP in bit 7; anything unlisted lights DP only.
  function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] ch);
    logic [SEG_W-1:0] seg;
    unique case (ch)
      "0": seg = 8'h3F;
      "1": seg = 8'h06;
      "2": seg = 8'h5B;
      "3": seg = 8'h4F;
      "4": seg = 8'h66;
      "5": seg = 8'h6D;
      "6": seg = 8'h7D;
      "7": seg = 8'h07;
      "8": seg = 8'h7F;
      "9": seg = 8'h6F;
      "A": seg = 8'h77;
      "a": seg = 8'h5F;
      "b": seg = 8'h7C;
      "C": seg = 8'h39;
      "c": seg = 8'h58;
      "d": seg = 8'h5E;
      "E": seg = 8'h79;
      "F": seg = 8'h71;
      "G": seg = 8'h3D;
      "H": seg = 8'h76;
      "h": seg = 8'h74;
      "I": seg = 8'h30;
      "J": seg = 8'h1E;
      "K": seg = 8'h75;
      "L": seg = 8'h38;
      "M": seg = 8'h2B;
      "n": seg = 8'h54;
      "O": seg = 8'h3F;
      "o": seg = 8'h5C;
      "P": seg = 8'h73;
      "q": seg = 8'h67;
      "r": seg = 8'h50;
      "S": seg = 8'h6D;
      "t": seg = 8'h78;
      "U": seg = 8'h3E;
      "u": seg = 8'h1C;
      "V": seg = 8'h2A;
      "W": seg = 8'h7E;
      "X": seg = 8'h49;
      "y": seg = 8'h6E;
      "Z": seg = 8'h5B;
      "_": seg = 8'h08;
      default: seg = DP_ONLY;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ssd_if.sv =====
// ----------------------------------------------------------------------------
// ssd_if
// Valid/ready channels for requests in and digit results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssd_pkg::OP_W-1:0]     opcode;
  logic [ssd_pkg::CHAR_W-1:0]   character;

  modport source (output valid, output opcode, output character, input ready);
  modport sink   (input valid, input opcode, input character, output ready);
endinterface

interface ssd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssd_pkg::DIGIT_W-1:0]  digit_select;
  logic [ssd_pkg::SEG_W-1:0]    segments;

  modport source (output valid, output digit_select, output segments, input ready);
  modport sink   (input valid, input digit_select, input segments, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssd_ram.sv =====
// ----------------------------------------------------------------------------
// ssd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/ssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssd_ctrl
// String load, scroll and digit state; drives pattern store write and read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [ssd_pkg::OP_W-1:0]     opcode,
  input  wire logic [ssd_pkg::CHAR_W-1:0]   character,
  output      logic                         wr_en,
  output      logic [ssd_pkg::ADDR_W-1:0]   wr_addr,
  output      logic [ssd_pkg::SEG_W-1:0]    wr_data,
  output      logic [ssd_pkg::ADDR_W-1:0]   rd_addr,
  output      ssd_pkg::mux_req_t            mux_req
);

  logic [ssd_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [ssd_pkg::LEN_W-1:0]   pos_r, pos_nxt;
  logic                        fin_r, fin_nxt;
  logic [ssd_pkg::OFF_W-1:0]   off_r, off_nxt;
  logic                        up_r, up_nxt;
  logic [ssd_pkg::DIGIT_W-1:0] dig_r, dig_nxt;

  logic [ssd_pkg::LEN_W-1:0]   top;
  logic [ssd_pkg::LEN_W-1:0]   off_ext;
  logic [ssd_pkg::LEN_W-1:0]   off_clamp;
  logic [ssd_pkg::LEN_W-1:0]   off_inc;
  logic [ssd_pkg::LEN_W-1:0]   rd_pos;
  logic [ssd_pkg::LEN_W-1:0]   base_pos;
  logic [ssd_pkg::DIGIT_W-1:0] dig_next;

  // largest scroll offset, zero for short text
  assign top = (len_r >= ssd_pkg::DIGITS_L) ? (len_r - ssd_pkg::DIGITS_L) : '0;

  assign off_ext   = ssd_pkg::LEN_W'(off_r);
  assign off_clamp = (off_ext > top) ? top : off_ext;
  assign off_inc   = off_ext + ssd_pkg::LEN_W'(1);
  assign dig_next  = (dig_r == ssd_pkg::LAST_DIGIT) ? '0 : dig_r + ssd_pkg::DIGIT_W'(1);
  assign rd_pos    = off_clamp + ssd_pkg::LEN_W'(dig_next);
  assign rd_addr   = rd_pos[ssd_pkg::ADDR_W-1:0];

  // a finished string restarts at position zero on the next load
  assign base_pos  = fin_r ? '0 : pos_r;
  assign wr_addr   = base_pos[ssd_pkg::ADDR_W-1:0];
  assign wr_data   = ssd_pkg::glyph(character);

  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    fin_nxt       = fin_r;
    off_nxt       = off_r;
    up_nxt        = up_r;
    dig_nxt       = dig_r;
    wr_en         = 1'b0;
    mux_req.vld   = 1'b0;
    mux_req.digit = dig_next;
    mux_req.blank = !(rd_pos < len_r);
    if (accept) begin
      unique case (ssd_pkg::opcode_t'(opcode))
        ssd_pkg::OP_LOAD: begin
          if (fin_r) begin
            fin_nxt = 1'b0;
            pos_nxt = '0;
            len_nxt = '0;
            off_nxt = '0;
            up_nxt  = 1'b0;
          end
          if (character == ssd_pkg::CHAR_END) begin
            fin_nxt = 1'b1;
          end else if (base_pos < ssd_pkg::DEPTH_L) begin
            wr_en   = 1'b1;
            pos_nxt = base_pos + ssd_pkg::LEN_W'(1);
            len_nxt = base_pos + ssd_pkg::LEN_W'(1);
          end
        end
        ssd_pkg::OP_MUX: begin
          mux_req.vld = 1'b1;
          dig_nxt     = dig_next;
        end
        ssd_pkg::OP_SHIFT: begin
          if (up_r) begin
            if (off_inc > top) begin
              off_nxt = top[ssd_pkg::OFF_W-1:0];
              up_nxt  = 1'b0;
            end else begin
              off_nxt = off_inc[ssd_pkg::OFF_W-1:0];
            end
          end else if (off_r == '0) begin
            up_nxt = 1'b1;
          end else begin
            off_nxt = off_r - ssd_pkg::OFF_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pos_r <= '0;
      fin_r <= 1'b0;
      off_r <= '0;
      up_r  <= 1'b0;
      dig_r <= '0;
    end else begin
      len_r <= len_nxt;
      pos_r <= pos_nxt;
      fin_r <= fin_nxt;
      off_r <= off_nxt;
      up_r  <= up_nxt;
      dig_r <= dig_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ssd_out.sv =====
// ----------------------------------------------------------------------------
// ssd_out
// Read-align stage and output register for multiplex results.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_out (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ssd_pkg::mux_req_t           mux_req,
  input  wire logic [ssd_pkg::SEG_W-1:0]   rd_data,
  output      logic                        stage_free,
  ssd_out_if.source                        out_if
);

  logic                        s1_vld_r;
  logic [ssd_pkg::DIGIT_W-1:0] s1_digit_r;
  logic                        s1_blank_r;
  logic                        out_vld_r;
  logic [ssd_pkg::DIGIT_W-1:0] out_digit_r;
  logic [ssd_pkg::SEG_W-1:0]   out_seg_r;
  logic                        out_free;

  assign out_free   = !out_vld_r || out_if.ready;
  // s1 holds RAM read data; no new read until it moves on
  assign stage_free = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (stage_free) begin
        s1_vld_r <= mux_req.vld;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && mux_req.vld) begin
      s1_digit_r <= mux_req.digit;
      s1_blank_r <= mux_req.blank;
    end
    if (out_free && s1_vld_r) begin
      out_digit_r <= s1_digit_r;
      out_seg_r   <= s1_blank_r ? ssd_pkg::SEG_BLANK : rd_data;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.digit_select = out_digit_r;
  assign out_if.segments     = out_seg_r;

endmodule

`default_nettype wire

// ===== rtl/scrolling_seven_segment_driver.sv =====
// ----------------------------------------------------------------------------
// scrolling_seven_segment_driver
// Four-digit scrolling seven-segment driver with a 64-entry pattern store.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : requests {opcode, character}, taken when valid and ready are high.
//            opcode 0 loads one character (zero byte ends the string),
//            1 is a multiplex tick, 2 is a scroll shift tick, 3 is ignored.
//   out_if : one result {digit_select, segments} per multiplex tick only.
//            Segments: A..G in bits 0..6, DP in bit 7, active high.
// A multiplex tick taken on in_if passes the align stage, then the output register, and then shows on out_if.
// Throughput: one request per cycle while in_if.ready is high; the single read
//   port of the pattern store has its registered read data in the align stage.
// Loads and shift ticks finish at the edge they are taken.
// Stall: a held result is kept in the output register while the next
//   request is taken; with both align and output stages full, in_if.ready
//   drops until the receiver takes a result.
// Reset: rst_n (synchronous) clears length, position, scroll offset and
//   direction, active digit and both pipeline valids. The pattern store is
//   not cleared; only positions of the current string are ever shown.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_seven_segment_driver (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ssd_in_if.sink      in_if,
  ssd_out_if.source   out_if
);

  logic                        accept;
  logic                        stage_free;
  logic                        wr_en;
  logic [ssd_pkg::ADDR_W-1:0]  wr_addr;
  logic [ssd_pkg::SEG_W-1:0]   wr_data;
  logic [ssd_pkg::ADDR_W-1:0]  rd_addr;
  logic [ssd_pkg::SEG_W-1:0]   rd_data;
  ssd_pkg::mux_req_t           mux_req;

  // every opcode waits on the align stage; keeps control simple
  assign in_if.ready = stage_free;
  assign accept      = in_if.valid && stage_free;

  ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_if.opcode),
    .character (in_if.character),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .mux_req   (mux_req)
  );

  // pattern store: write on load, read on multiplex tick
  ssd_ram #(
    .WIDTH (ssd_pkg::SEG_W),
    .DEPTH (ssd_pkg::BUFFER_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mux_req.vld),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .mux_req    (mux_req),
    .rd_data    (rd_data),
    .stage_free (stage_free),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

// ===== rtl/ssd_chk.sv =====
// ----------------------------------------------------------------------------
// ssd_chk
// Port-level checks for the scrolling display driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ssd_pkg::DIGIT_W-1:0] out_digit_select,
  input wire logic [ssd_pkg::SEG_W-1:0]   out_segments
);

  logic [ssd_pkg::DIGIT_W-1:0] last_digit_r;
  logic [ssd_pkg::DIGIT_W-1:0] expect_digit;

  assign expect_digit = (last_digit_r == ssd_pkg::LAST_DIGIT) ? '0 :
                        last_digit_r + ssd_pkg::DIGIT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_digit_r <= '0;
    end else if (out_valid && out_ready) begin
      last_digit_r <= out_digit_select;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_select) &&
    $stable(out_segments))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request stalled with empty output");

  a_digit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_digit_select == expect_digit)
    else $error("digit index skipped or repeated");

  // a result needs an earlier request that passed the align stage, then the output register
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid && in_ready, 2) && !$past(out_valid) |-> !out_valid)
    else $error("result without a request");

endmodule

bind scrolling_seven_segment_driver ssd_chk u_ssd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_digit_select (out_if.digit_select),
  .out_segments     (out_if.segments)
);

`default_nettype wire
